/* hw/rtl/asi_pkg.sv */
// Package with the shared types and constants of the accumulation swing index block.
package asi_pkg;

   // Fixed field widths.
   localparam int SI_BITS    = 36;
   localparam int ASI_BITS   = 41;
   localparam int TOTAL_BITS = 45;
   localparam int SIW_BITS   = 6;
   localparam int AVGW_BITS  = 5;
   localparam int CSR_BITS   = 6;

   // Configuration register indexes.
   localparam logic CSR_SI_WINDOW  = 1'b0;
   localparam logic CSR_AVG_WINDOW = 1'b1;
   localparam logic [SIW_BITS-1:0]  SI_WINDOW_RESET  = 6'd26;
   localparam logic [AVGW_BITS-1:0] AVG_WINDOW_RESET = 5'd10;

   // Operation codes.
   localparam logic OP_BAR   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TERMS,
      ST_MUL,
      ST_DIV,
      ST_SCALE,
      ST_SI_DROP,
      ST_SI_PUSH,
      ST_AVG_DROP,
      ST_AVG_PUSH,
      ST_AVG_DIV,
      ST_OUT
   } state_type;

endpackage

/* hw/rtl/asi_if.sv */
// Valid/ready channel interfaces for the request and response transactions.
interface asi_req_if #(parameter int PRICE_BITS = 24);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [PRICE_BITS-1:0] open_price;
   logic [PRICE_BITS-1:0] high_price;
   logic [PRICE_BITS-1:0] low_price;
   logic [PRICE_BITS-1:0] close_price;
   modport source (output valid, op, open_price, high_price, low_price, close_price,
                   input ready);
   modport sink   (input valid, op, open_price, high_price, low_price, close_price,
                   output ready);
endinterface

interface asi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [35:0] swing_index;
   logic signed [40:0] asi_value;
   logic signed [40:0] asi_average;
   logic               zero_range;
   modport source (output valid, swing_index, asi_value, asi_average, zero_range,
                   input ready);
   modport sink   (input valid, swing_index, asi_value, asi_average, zero_range,
                   output ready);
endinterface

/* hw/rtl/accumulation_swing_index.sv */
// Top level of the accumulation swing index engine.
//
// Channel  Direction  Handshake      Payload
// req      in         valid/ready    op, open/high/low/close price
// rsp      out        valid/ready    swing_index, asi_value, asi_average, zero_range
// csr      in         write enable   csr_index, csr_data
//
// A bar passes through a serial multiply of |2X| by K, a serial divide by 4R and a serial
// divide of the window total by avg_window, each one bit per cycle, plus a ring read and
// a retire step per dropped ring entry. A clear gives no response.
// Reset is synchronous and restores the windows, sums and previous bar. A new request
// is taken once the previous response has been handed over; rsp stalls hold the response.
module accumulation_swing_index
   import asi_pkg::*;
#(
   parameter int MAX_SI_WINDOW  = 32,
   parameter int MAX_AVG_WINDOW = 16,
   parameter int PRICE_BITS     = 24
) (
   input  logic                clock,
   input  logic                reset,
   asi_req_if.sink             req,
   asi_rsp_if.source           rsp,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);
   localparam int SIH_BITS  = (MAX_SI_WINDOW > 1) ? $clog2(MAX_SI_WINDOW) : 1;
   localparam int AVH_BITS  = (MAX_AVG_WINDOW > 1) ? $clog2(MAX_AVG_WINDOW) : 1;
   localparam int SIC_BITS  = $clog2(MAX_SI_WINDOW + 1);
   localparam int AVC_BITS  = $clog2(MAX_AVG_WINDOW + 1);
   localparam int T_BITS    = PRICE_BITS + 4;   // 4R and |2X| headroom
   localparam int P_BITS    = T_BITS + PRICE_BITS;
   localparam int NUM_BITS  = P_BITS + 9;       // product times 512
   localparam logic [35:0] SI_POS_MAX = {1'b0, {35{1'b1}}};
   localparam logic [NUM_BITS-1:0] SAT_LIM = NUM_BITS'(64'd1 << 35);

   // Configuration registers.
   logic [SIW_BITS-1:0]  si_window_ff;
   logic [AVGW_BITS-1:0] avg_window_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         si_window_ff  <= SI_WINDOW_RESET;
         avg_window_ff <= AVG_WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SI_WINDOW:  si_window_ff  <= csr_data;
            CSR_AVG_WINDOW: avg_window_ff <= csr_data[AVGW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective window sizes.
   logic [SIC_BITS-1:0] si_w;
   logic [AVC_BITS-1:0] avg_w;
   always_comb begin
      if (si_window_ff == '0) si_w = SIC_BITS'(1);
      else if (32'(si_window_ff) > MAX_SI_WINDOW) si_w = SIC_BITS'(MAX_SI_WINDOW);
      else si_w = SIC_BITS'(si_window_ff);
      if (avg_window_ff == '0) avg_w = AVC_BITS'(1);
      else if (32'(avg_window_ff) > MAX_AVG_WINDOW) avg_w = AVC_BITS'(MAX_AVG_WINDOW);
      else avg_w = AVC_BITS'(avg_window_ff);
   end

   state_type state_ff, state_in;

   logic [PRICE_BITS-1:0] prev_open_ff, prev_low_ff, prev_close_ff;
   logic [PRICE_BITS-1:0] o_ff, h_ff, l_ff, c_ff;
   logic [T_BITS-1:0]     r4_ff;
   logic                  neg_ff, zr_ff;
   logic signed [35:0]    si_ff, si_in;
   logic signed [ASI_BITS-1:0]   running_ff;
   logic signed [TOTAL_BITS-1:0] total_ff;
   logic [SIC_BITS-1:0]   si_count_ff;
   logic [SIH_BITS-1:0]   si_head_ff;
   logic [AVC_BITS-1:0]   asi_count_ff;
   logic [AVH_BITS-1:0]   asi_head_ff;
   logic signed [ASI_BITS-1:0] avg_ff;
   logic                  tneg_ff;

   // Ring memories, read through a registered port.
   logic signed [35:0]         si_ring [MAX_SI_WINDOW];
   logic signed [ASI_BITS-1:0] asi_ring [MAX_AVG_WINDOW];
   logic signed [35:0]         si_rd_ff;
   logic signed [ASI_BITS-1:0] asi_rd_ff;
   logic                       rd_ok_ff;
   logic [SIH_BITS-1:0]        si_old;
   logic [AVH_BITS-1:0]        asi_old;

   // The oldest entry sits count places behind the head, wrapping at the ring depth.
   assign si_old  = (32'(si_head_ff) >= 32'(si_count_ff))
                  ? SIH_BITS'(32'(si_head_ff) - 32'(si_count_ff))
                  : SIH_BITS'(32'(si_head_ff) + MAX_SI_WINDOW - 32'(si_count_ff));
   assign asi_old = (32'(asi_head_ff) >= 32'(asi_count_ff))
                  ? AVH_BITS'(32'(asi_head_ff) - 32'(asi_count_ff))
                  : AVH_BITS'(32'(asi_head_ff) + MAX_AVG_WINDOW - 32'(asi_count_ff));

   // Serial arithmetic units.
   logic mul_start, mul_done, div_start, div_done;
   logic [P_BITS-1:0]     prod;
   logic [NUM_BITS-1:0]   d_numer, d_quot;
   logic [T_BITS-1:0]     d_denom;
   logic [T_BITS-1:0]     m_c;
   logic [PRICE_BITS-1:0] k_c;

   asi_serial_mul #(.A_BITS(T_BITS), .B_BITS(PRICE_BITS)) u_mul (
      .clock, .reset, .start(mul_start), .mcand(m_c), .mplier(k_c),
      .done(mul_done), .prod(prod)
   );

   asi_serial_div #(.N_BITS(NUM_BITS), .D_BITS(T_BITS)) u_div (
      .clock, .reset, .start(div_start), .numer(d_numer), .denom(d_denom),
      .done(div_done), .quot(d_quot)
   );

   // Bar terms, formed from the captured bar and the previous bar.
   logic [PRICE_BITS:0] ta, tb, tc, td;
   logic [T_BITS-1:0]   r4_c;
   logic signed [T_BITS:0] x2_c;
   logic signed [T_BITS:0] c_s, o_s, pc_s, po_s;
   always_comb begin
      ta = (h_ff > prev_close_ff) ? (PRICE_BITS+1)'(h_ff - prev_close_ff)
                                  : (PRICE_BITS+1)'(prev_close_ff - h_ff);
      tb = (l_ff > prev_close_ff) ? (PRICE_BITS+1)'(l_ff - prev_close_ff)
                                  : (PRICE_BITS+1)'(prev_close_ff - l_ff);
      tc = (h_ff > prev_low_ff) ? (PRICE_BITS+1)'(h_ff - prev_low_ff)
                                : (PRICE_BITS+1)'(prev_low_ff - h_ff);
      td = (prev_close_ff > prev_open_ff) ? (PRICE_BITS+1)'(prev_close_ff - prev_open_ff)
                                          : (PRICE_BITS+1)'(prev_open_ff - prev_close_ff);
      if (ta > tb && ta > tc)
         r4_c = (T_BITS'(ta) << 2) + (T_BITS'(tb) << 1) + T_BITS'(td);
      else if (tb > ta && tb > tc)
         r4_c = (T_BITS'(tb) << 2) + (T_BITS'(ta) << 1) + T_BITS'(td);
      else
         r4_c = (T_BITS'(tc) << 2) + T_BITS'(td);
      c_s  = (T_BITS+1)'($signed({1'b0, c_ff}));
      o_s  = (T_BITS+1)'($signed({1'b0, o_ff}));
      pc_s = (T_BITS+1)'($signed({1'b0, prev_close_ff}));
      po_s = (T_BITS+1)'($signed({1'b0, prev_open_ff}));
      x2_c = ((c_s - pc_s) <<< 1) + (c_s - o_s) + ((pc_s - po_s) <<< 1);
      m_c  = x2_c[T_BITS] ? T_BITS'(-x2_c) : T_BITS'(x2_c);
      k_c  = (ta > tb) ? PRICE_BITS'(ta) : PRICE_BITS'(tb);
   end

   // Divider operand select: SI quotient or window average.
   logic [TOTAL_BITS-1:0] tot_mag;
   assign tot_mag = total_ff[TOTAL_BITS-1] ? TOTAL_BITS'(-total_ff) : TOTAL_BITS'(total_ff);
   always_comb begin
      if (state_ff == ST_AVG_DIV) begin
         d_numer = NUM_BITS'(tot_mag);
         d_denom = T_BITS'(avg_w);
      end else begin
         d_numer = NUM_BITS'(prod) << 9;
         d_denom = r4_ff;
      end
   end

   // Saturated, signed SI from the quotient.
   logic [NUM_BITS-1:0] q_sat;
   always_comb begin
      q_sat = (d_quot > SAT_LIM) ? SAT_LIM : d_quot;
      if (zr_ff)
         si_in = '0;
      else if (neg_ff)
         si_in = -$signed(36'(q_sat));
      else
         si_in = (q_sat > NUM_BITS'(SI_POS_MAX)) ? $signed(SI_POS_MAX) : $signed(36'(q_sat));
   end

   logic req_take, rsp_take, si_drop, avg_drop;
   assign req_take = req.valid && req.ready;
   assign rsp_take = rsp.valid && rsp.ready;
   assign si_drop  = si_count_ff >= si_w;
   assign avg_drop = AVC_BITS'(asi_count_ff) >= avg_w;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_take && req.op == OP_BAR) state_in = ST_TERMS;
         ST_TERMS:    state_in = ST_MUL;
         ST_MUL:      if (mul_done) state_in = ST_DIV;
         ST_DIV:      if (div_done) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_SI_DROP;
         ST_SI_DROP:  if (!si_drop && !rd_ok_ff) state_in = ST_SI_PUSH;
         ST_SI_PUSH:  state_in = ST_AVG_DROP;
         ST_AVG_DROP: if (!avg_drop && !rd_ok_ff) state_in = ST_AVG_PUSH;
         ST_AVG_PUSH: state_in = ST_AVG_DIV;
         ST_AVG_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:      if (rsp_take) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   logic div_go_ff;
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_OUT);
      mul_start = (state_ff == ST_TERMS);
      div_start = (state_ff == ST_MUL && mul_done) || div_go_ff;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_open_ff  <= '0;
         prev_low_ff   <= '0;
         prev_close_ff <= '0;
         si_count_ff   <= '0;
         si_head_ff    <= '0;
         asi_count_ff  <= '0;
         asi_head_ff   <= '0;
         running_ff    <= '0;
         total_ff      <= '0;
         rd_ok_ff      <= 1'b0;
         div_go_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= (state_ff == ST_AVG_PUSH);
         // A ring read is issued in the cycle before the entry is retired.
         rd_ok_ff  <= !rd_ok_ff && ((state_ff == ST_SI_DROP && si_drop)
                                    || (state_ff == ST_AVG_DROP && avg_drop));
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take && req.op == OP_CLEAR) begin
                  si_count_ff  <= '0;
                  si_head_ff   <= '0;
                  asi_count_ff <= '0;
                  asi_head_ff  <= '0;
                  running_ff   <= '0;
                  total_ff     <= '0;
               end
            end
            ST_SI_DROP: begin
               // Retire the oldest entry fetched the cycle before.
               if (rd_ok_ff) begin
                  running_ff  <= running_ff - ASI_BITS'(si_rd_ff);
                  si_count_ff <= si_count_ff - 1'b1;
               end
            end
            ST_SI_PUSH: begin
               si_head_ff  <= SIH_BITS'(32'(si_head_ff) + 1 == MAX_SI_WINDOW ? 0
                                        : 32'(si_head_ff) + 1);
               si_count_ff <= si_count_ff + 1'b1;
               running_ff  <= running_ff + ASI_BITS'(si_ff);
            end
            ST_AVG_DROP: begin
               if (rd_ok_ff) begin
                  total_ff     <= total_ff - TOTAL_BITS'(asi_rd_ff);
                  asi_count_ff <= asi_count_ff - 1'b1;
               end
            end
            ST_AVG_PUSH: begin
               asi_head_ff  <= AVH_BITS'(32'(asi_head_ff) + 1 == MAX_AVG_WINDOW ? 0
                                         : 32'(asi_head_ff) + 1);
               asi_count_ff <= asi_count_ff + 1'b1;
               total_ff     <= total_ff + TOTAL_BITS'(running_ff);
               prev_open_ff  <= o_ff;
               prev_low_ff   <= l_ff;
               prev_close_ff <= c_ff;
            end
            default: ;
         endcase
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         o_ff <= req.open_price;
         h_ff <= req.high_price;
         l_ff <= req.low_price;
         c_ff <= req.close_price;
      end
      if (state_ff == ST_TERMS) begin
         r4_ff  <= r4_c;
         zr_ff  <= (r4_c == '0);
         neg_ff <= x2_c[T_BITS];
      end
      if (state_ff == ST_SCALE) si_ff <= si_in;
      // The total sign is taken when the average division starts, after the push.
      if (state_ff == ST_AVG_DIV && div_go_ff) tneg_ff <= total_ff[TOTAL_BITS-1];
      if (state_ff == ST_AVG_DIV && div_done) begin
         avg_ff <= tneg_ff ? -$signed(ASI_BITS'(d_quot)) : $signed(ASI_BITS'(d_quot));
      end
      si_rd_ff  <= si_ring[si_old];
      asi_rd_ff <= asi_ring[asi_old];
      if (state_ff == ST_SI_PUSH)  si_ring[si_head_ff]   <= si_ff;
      if (state_ff == ST_AVG_PUSH) asi_ring[asi_head_ff] <= running_ff;
   end

   assign rsp.swing_index = si_ff;
   assign rsp.asi_value   = running_ff;
   assign rsp.asi_average = avg_ff;
   assign rsp.zero_range  = zr_ff;
endmodule

/* hw/rtl/asi_serial_div.sv */
// Restoring divider that retires one quotient bit per cycle.
module asi_serial_div
   import asi_pkg::*;
#(
   parameter int N_BITS = 64,
   parameter int D_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [N_BITS-1:0] numer,
   input  logic [D_BITS-1:0] denom,
   output logic              done,
   output logic [N_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(N_BITS + 1);

   logic [N_BITS-1:0]   q_ff, q_in;
   logic [D_BITS:0]     rem_ff, rem_in;
   logic [D_BITS-1:0]   den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in, done_ff, done_in;
   logic [D_BITS:0]     trial;
   logic [D_BITS:0]     diff;

   // One shift-subtract step per cycle.
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[D_BITS-1:0], q_ff[N_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         q_in   = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_BITS'(N_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[D_BITS]) begin
            rem_in = diff;
            q_in   = {q_ff[N_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[N_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

/* hw/rtl/asi_serial_mul.sv */
// Shift-add multiplier that consumes one multiplier bit per cycle.
module asi_serial_mul
   import asi_pkg::*;
#(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [A_BITS-1:0]        mcand,
   input  logic [B_BITS-1:0]        mplier,
   output logic                     done,
   output logic [A_BITS+B_BITS-1:0] prod
);
   localparam int CNT_BITS = $clog2(B_BITS + 1);

   logic [A_BITS+B_BITS-1:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [B_BITS-1:0]        mp_ff, mp_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     run_ff, run_in, done_ff, done_in;

   // Add the shifted multiplicand when the low multiplier bit is set.
   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mc_in  = (A_BITS+B_BITS)'(mcand);
         mp_in  = mplier;
         cnt_in = CNT_BITS'(B_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

/* dv/asi_checker.sv */
// Checker that watches the swing index channels and compares responses with predicted values.
`timescale 1ns / 100ps

module asi_checker
   import asi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   asi_req_if                  req,
   asi_rsp_if                  rsp,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_data,
   output int                  failures,
   output int                  pending
);

   localparam longint SI_MAX = 64'sd34359738367;
   localparam longint SI_MIN = -64'sd34359738368;
   localparam int     MAX_SIW   = 32;
   localparam int     MAX_AVGW  = 16;
   localparam int     EXP_DEPTH = 4;

   typedef struct {
      logic signed [SI_BITS-1:0]  swing_index;
      logic signed [ASI_BITS-1:0] asi_value;
      logic signed [ASI_BITS-1:0] asi_average;
      logic                       zero_range;
   } swing_result_type;

   // Mirrored configuration and state of the engine.
   logic [SIW_BITS-1:0]  si_window_cfg;
   logic [AVGW_BITS-1:0] avg_window_cfg;
   longint prev_o, prev_l, prev_c;
   longint si_vals[MAX_SIW];
   int     si_cnt, si_hd;
   longint asi_vals[MAX_AVGW];
   int     asi_cnt, asi_hd;
   longint asi_sum, avg_total;

   // Expected responses in request order.
   swing_result_type exp_fifo[EXP_DEPTH];
   int               exp_wr, exp_rd, exp_cnt;

   function automatic longint absdiff(longint x, longint y);
      return (x > y) ? x - y : y - x;
   endfunction

   function automatic int clamp_window(int v, int maxw);
      if (v < 1) return 1;
      if (v > maxw) return maxw;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   task automatic clear_sums();
      si_cnt = 0;
      si_hd = 0;
      asi_cnt = 0;
      asi_hd = 0;
      asi_sum = 0;
      avg_total = 0;
   endtask

   // Compute the swing index, the sliding sums and the average for one bar.
   task automatic predict_bar(input longint o, input longint h, input longint l,
                              input longint c);
      longint a, b, cc, d, r4, x2, k, si, avg_q;
      longint unsigned m, q;
      int w, old;
      swing_result_type res;
      a  = absdiff(h, prev_c);
      b  = absdiff(l, prev_c);
      cc = absdiff(h, prev_l);
      d  = absdiff(prev_c, prev_o);
      if (a > b && a > cc) r4 = 4 * a + 2 * b + d;
      else if (b > a && b > cc) r4 = 4 * b + 2 * a + d;
      else r4 = 4 * cc + d;
      x2 = 2 * (c - prev_c) + (c - o) + 2 * (prev_c - prev_o);
      k  = (a > b) ? a : b;
      res.zero_range = (r4 == 0);
      if (r4 == 0) begin
         si = 0;
      end else begin
         // The product stays below 2^61, so the scaled quotient is exact in 64 bits.
         m = (x2 < 0) ? longint'(-x2) : longint'(x2);
         q = (m * longint'(k) * 512) / longint'(r4);
         if (q > (64'd1 << 35)) q = 64'd1 << 35;
         if (x2 < 0) si = -longint'(q);
         else si = (q > SI_MAX) ? SI_MAX : longint'(q);
         if (si < SI_MIN) si = SI_MIN;
      end
      // Slide the swing index window.
      w = clamp_window(int'(si_window_cfg), MAX_SIW);
      while (si_cnt >= w) begin
         old = (si_hd + MAX_SIW - si_cnt) % MAX_SIW;
         asi_sum -= si_vals[old];
         si_cnt--;
      end
      si_vals[si_hd] = si;
      si_hd = (si_hd + 1) % MAX_SIW;
      si_cnt++;
      asi_sum += si;
      // Slide the ASI window used by the average.
      w = clamp_window(int'(avg_window_cfg), MAX_AVGW);
      while (asi_cnt >= w) begin
         old = (asi_hd + MAX_AVGW - asi_cnt) % MAX_AVGW;
         avg_total -= asi_vals[old];
         asi_cnt--;
      end
      asi_vals[asi_hd] = asi_sum;
      asi_hd = (asi_hd + 1) % MAX_AVGW;
      asi_cnt++;
      avg_total += asi_sum;
      prev_o = o;
      prev_l = l;
      prev_c = c;
      avg_q = avg_total / w;
      res.swing_index = si[SI_BITS-1:0];
      res.asi_value   = asi_sum[ASI_BITS-1:0];
      res.asi_average = avg_q[ASI_BITS-1:0];
      if (exp_cnt == EXP_DEPTH) begin
         report_mismatch("outstanding requests", exp_cnt + 1, EXP_DEPTH);
      end else begin
         exp_fifo[exp_wr] = res;
         exp_wr = (exp_wr + 1) % EXP_DEPTH;
         exp_cnt++;
      end
   endtask

   // Track configuration, predict accepted requests and check accepted responses.
   always @(posedge clock) begin
      swing_result_type want;
      if (reset) begin
         si_window_cfg  = SI_WINDOW_RESET;
         avg_window_cfg = AVG_WINDOW_RESET;
         prev_o = 0;
         prev_l = 0;
         prev_c = 0;
         clear_sums();
         exp_wr  = 0;
         exp_rd  = 0;
         exp_cnt = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_SI_WINDOW) si_window_cfg = csr_data[SIW_BITS-1:0];
            else avg_window_cfg = csr_data[AVGW_BITS-1:0];
         end
         if (rsp.valid && rsp.ready) begin
            if (exp_cnt == 0) begin
               report_mismatch("response transaction with no request pending", 1, 0);
            end else begin
               want = exp_fifo[exp_rd];
               exp_rd = (exp_rd + 1) % EXP_DEPTH;
               exp_cnt--;
               if (rsp.swing_index !== want.swing_index)
                  report_mismatch("swing_index", rsp.swing_index, want.swing_index);
               if (rsp.asi_value !== want.asi_value)
                  report_mismatch("asi_value", rsp.asi_value, want.asi_value);
               if (rsp.asi_average !== want.asi_average)
                  report_mismatch("asi_average", rsp.asi_average, want.asi_average);
               if (rsp.zero_range !== want.zero_range)
                  report_mismatch("zero_range", rsp.zero_range, want.zero_range);
            end
         end
         if (req.valid && req.ready) begin
            if (req.op == OP_CLEAR) clear_sums();
            else predict_bar(req.open_price, req.high_price, req.low_price,
                             req.close_price);
         end
      end
      pending = exp_cnt;
   end

endmodule

/* dv/accumulation_swing_index_tb.sv */
// Top of the accumulation swing index testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module accumulation_swing_index_tb;
   import asi_pkg::*;

   localparam int PMAX = 24'hFFFFFF;

   logic                clock;
   logic                reset;
   logic                csr_write;
   logic                csr_index;
   logic [CSR_BITS-1:0] csr_data;
   int                  failures;
   int                  pending;
   bit                  sender_calm;
   bit                  receiver_calm;
   int                  last_close;

   asi_req_if #(.PRICE_BITS(24)) req ();
   asi_rsp_if rsp ();

   accumulation_swing_index dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req.sink),
      .rsp      (rsp.source),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   asi_checker checker_inst (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .failures (failures),
      .pending  (pending)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Send one transaction after a random gap and wait until it is taken.
   task automatic send_item(input logic op, input int o, input int h, input int l,
                            input int c);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(3);
      repeat (gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.op          <= op;
      req.open_price  <= o[23:0];
      req.high_price  <= h[23:0];
      req.low_price   <= l[23:0];
      req.close_price <= c[23:0];
      if (op == OP_BAR) last_close = c;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   // Write both window registers once the engine has drained.
   task automatic set_windows(input int siw, input int avgw);
      req.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_SI_WINDOW;
      csr_data  <= siw[CSR_BITS-1:0];
      @(negedge clock);
      csr_index <= CSR_AVG_WINDOW;
      csr_data  <= avgw[CSR_BITS-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Random bar: mostly well formed around the last close, some noise and clears.
   task automatic send_random_bar();
      int kind, span, base, o, h, l, c;
      kind = $urandom_range(99);
      if (kind < 3) begin
         send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 15) begin
         send_item(OP_BAR, $urandom & PMAX, $urandom & PMAX, $urandom & PMAX,
                   $urandom & PMAX);
      end else if (kind < 20) begin
         send_item(OP_BAR, last_close, last_close, last_close, last_close);
      end else begin
         case ($urandom_range(2))
            0: span = 3;
            1: span = 255;
            default: span = 65535;
         endcase
         base = last_close + $urandom_range(2 * span) - span;
         if (base < 0) base = 0;
         if (base > PMAX - 2 * span) base = PMAX - 2 * span;
         l = base + $urandom_range(span);
         h = l + $urandom_range(span);
         o = $urandom_range(h, l);
         c = $urandom_range(h, l);
         send_item(OP_BAR, o, h, l, c);
      end
   endtask

   // Response side: random stalls per transaction, with calm stretches.
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = receiver_calm ? 0 : $urandom_range(3);
         repeat (gap) begin
            rsp.ready <= 1'b0;
            @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
         @(negedge clock);
      end
   end

   // Guard against a hung run.
   initial begin
      #8000000;
      $display("accumulation_swing_index: mismatch");
      $finish;
   end

   initial begin
      int siw_list[8] = '{26, 1, 32, 0, 63, 5, 2, 17};
      int avg_list[8] = '{10, 1, 16, 0, 31, 3, 16, 7};
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = CSR_SI_WINDOW;
      csr_data      = '0;
      req.valid     = 1'b0;
      req.op        = OP_BAR;
      req.open_price  = '0;
      req.high_price  = '0;
      req.low_price   = '0;
      req.close_price = '0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      last_close    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed bars at reset windows: first bar of zeros gives a zero range.
      send_item(OP_BAR, 0, 0, 0, 0);
      send_item(OP_BAR, PMAX, PMAX, PMAX, PMAX);
      send_item(OP_BAR, PMAX, PMAX, PMAX, PMAX);
      send_item(OP_BAR, 0, PMAX, 0, PMAX);
      send_item(OP_BAR, PMAX, PMAX, 0, 0);
      send_item(OP_CLEAR, PMAX, PMAX, PMAX, PMAX);
      send_item(OP_BAR, 0, 0, 0, 0);
      // Tied terms with a tiny range drive the swing index into saturation.
      send_item(OP_BAR, 99, 0, 200, 100);
      send_item(OP_BAR, 100, 100, 100, 100);
      send_item(OP_BAR, 99, 0, 200, 100);
      send_item(OP_BAR, 0, 200, 0, PMAX);
      send_item(OP_BAR, 99, 0, 200, 100);
      send_item(OP_BAR, PMAX, 200, 0, 0);
      send_item(OP_BAR, 12345, 23456, 1000, 20000);
      send_item(OP_CLEAR, 0, 0, 0, 0);
      send_item(OP_BAR, 20000, 30000, 15000, 16000);

      // Random phases over a spread of window settings, with a mid-run shrink.
      for (int p = 0; p < 8; p++) begin
         set_windows(siw_list[p], avg_list[p]);
         for (int i = 0; i < 205; i++) begin
            sender_calm   = (p == 2) || (i >= 150 && i < 180);
            receiver_calm = (p == 5) || (i >= 100 && i < 130);
            send_random_bar();
         end
      end
      req.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (failures == 0) begin
         $display("accumulation_swing_index: match");
      end else begin
         $display("accumulation_swing_index: mismatch");
      end
      $finish;
   end

endmodule
